FILE: rtl/core/qbpg_pkg.sv
package qbpg_pkg;

  localparam int BaseSegments = 10;
  localparam int SegBits = 6;
  localparam logic [SegBits-1:0] SegLimit = 6'd63;
  localparam logic [23:0] BodyLengthReset = 24'd19661;
  localparam int AddrBits = 1;
  localparam logic [AddrBits-1:0] RegBodyLength = 1'b0;

  typedef logic [31:0] coord_t;

endpackage

FILE: rtl/core/quadratic_bezier_path_generator.sv
// Quadratic Bezier path generator. Points arrive as start, control, end,
// control, end, ...; each end point closes a curve. The block then emits
// n+1 points for the first curve of a path and n points for later curves,
// where n is the base count of 10 or the boosted count (up to 63). Input
// stall is high while an item is being worked. For each point and each
// coordinate, three products on the shared 33x33 multiplier and an add of
// half the divisor build the rounded numerator, and a 64-step restoring
// divider (one quotient bit a cycle) divides it by n*n; S_EMIT then loads
// the output register. The start-to-control distance uses the same
// multiplier for the squared differences and a 32-step square root, then
// S_AVG and S_SEG form the average and the segment count. After a closing
// item is taken, input stall stays high until the last point of the curve
// is loaded, which a point waiting on out_stall_i delays. Start and control
// items are taken in S_IDLE and raise no stall.
module quadratic_bezier_path_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [qbpg_pkg::AddrBits+1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        path_start_i,
  input  logic        force_boost_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic        run_last_o
);
  import qbpg_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DSQ, S_SQRT, S_AVG, S_SEG, S_START, S_MUL, S_DIV, S_EMIT
  } state_e;

  state_e state_q;
  logic [23:0] body_q;
  coord_t sx_q, sy_q, cx_q, cy_q, ex_q, ey_q;
  logic [1:0] phase_q;
  logic [31:0] avg_q;
  logic first_q, force_q;
  logic [63:0] rad_q;
  logic [31:0] root_q;
  logic [65:0] rem_q;
  logic [5:0] cnt_q;
  logic [5:0] n_q, j_q;
  logic [1:0] term_q;
  logic axis_q;
  logic [65:0] num_q;
  logic [30:0] quo_q;
  logic [11:0] den_q;
  logic [31:0] rx_q, ry_q;
  logic [31:0] ox_q, oy_q;
  logic last_q, ovalid_q;

  // register write and read
  logic wr_en;
  assign wr_en = psel && penable && pwrite && (paddr[AddrBits+1:2] == RegBodyLength);
  assign pready = 1'b1;
  assign prdata = (paddr[AddrBits+1:2] == RegBodyLength) ? {8'd0, body_q} : 32'd0;

  // distance differences
  logic [32:0] dxs, dys, adx, ady;
  assign dxs = {1'b0, sx_q ^ 32'h8000_0000} - {1'b0, cx_q ^ 32'h8000_0000};
  assign dys = {1'b0, sy_q ^ 32'h8000_0000} - {1'b0, cy_q ^ 32'h8000_0000};
  assign adx = dxs[32] ? 33'(-dxs) : dxs;
  assign ady = dys[32] ? 33'(-dys) : dys;

  // shared multiplier operands
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic [65:0] acc_sum;
  logic [5:0] k;
  logic [31:0] p0, p1, p2, psel_pt;
  assign k = n_q - j_q;
  assign p0 = axis_q ? sy_q : sx_q;
  assign p1 = axis_q ? cy_q : cx_q;
  assign p2 = axis_q ? ey_q : ex_q;
  always_comb begin
    case (term_q)
      2'd0: begin
        psel_pt = p0;
        mul_b = {21'd0, 6'd0, k} * {27'd0, k};
      end
      2'd1: begin
        psel_pt = p1;
        mul_b = {20'd0, j_q, 1'b0} * {27'd0, k};
      end
      default: begin
        psel_pt = p2;
        mul_b = {27'd0, j_q} * {27'd0, j_q};
      end
    endcase
    mul_a = {1'b0, psel_pt ^ 32'h8000_0000};
    // square the distance differences
    if (state_q == S_DSQ) begin
      mul_a = term_q[0] ? ady : adx;
      mul_b = mul_a;
    end
    mul_p = {33'd0, mul_a} * {33'd0, mul_b};
  end
  assign acc_sum = num_q + mul_p;

  // square root step, one root bit per cycle
  logic [65:0] sq_try;
  logic [63:0] sq_shift;
  assign sq_shift = {rem_q[61:0], rad_q[63:62]};
  assign sq_try = {2'b0, sq_shift} - {32'd0, root_q, 2'b01};

  // divider step
  logic [65:0] dv_shift, dv_try;
  assign dv_shift = {rem_q[64:0], num_q[63]};
  assign dv_try = dv_shift - {54'd0, den_q};

  logic [32:0] avg_sum;
  logic [33:0] thresh;
  logic [31:0] extra;
  logic [31:0] total;
  assign avg_sum = {1'b0, avg_q} + {1'b0, root_q};
  assign thresh = {2'b0, avg_q} + {10'd0, body_q};
  assign extra = 32'(({8'd0, body_q} * 32'(BaseSegments * 2)) >> 16);
  assign total = extra + 32'(BaseSegments);

  // output register load
  logic out_load;
  assign out_load = ((state_q == S_START) || (state_q == S_EMIT)) &&
                    (!ovalid_q || !out_stall_i);

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign run_last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      body_q <= BodyLengthReset;
      sx_q <= '0; sy_q <= '0; cx_q <= '0; cy_q <= '0; ex_q <= '0; ey_q <= '0;
      phase_q <= 2'd0;
      avg_q <= '0;
      first_q <= 1'b1;
      force_q <= 1'b0;
      rad_q <= '0;
      root_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
      n_q <= '0;
      j_q <= '0;
      term_q <= 2'd0;
      axis_q <= 1'b0;
      num_q <= '0;
      quo_q <= '0;
      den_q <= '0;
      rx_q <= '0;
      ry_q <= '0;
      ox_q <= '0;
      oy_q <= '0;
      last_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        body_q <= pwdata[23:0];
      end
      if (ovalid_q && !out_stall_i && !out_load) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (path_start_i) begin
              avg_q <= '0;
              first_q <= 1'b1;
            end
            if (path_start_i || phase_q != 2'd2 && phase_q != 2'd1) begin
              sx_q <= point_x_i; sy_q <= point_y_i; phase_q <= 2'd1;
            end else if (phase_q == 2'd1) begin
              cx_q <= point_x_i; cy_q <= point_y_i; phase_q <= 2'd2;
            end else begin
              ex_q <= point_x_i; ey_q <= point_y_i; force_q <= force_boost_i;
              num_q <= '0;
              term_q <= 2'd0;
              state_q <= S_DSQ;
            end
          end
        end
        // sum the squared differences, saturate past 64 bits
        S_DSQ: begin
          if (term_q == 2'd0) begin
            num_q <= acc_sum;
            term_q <= 2'd1;
          end else begin
            num_q <= '0;
            term_q <= 2'd0;
            if (acc_sum[64]) begin
              root_q <= '1;
              state_q <= S_AVG;
            end else begin
              rad_q <= acc_sum[63:0];
              root_q <= '0; rem_q <= '0; cnt_q <= '0;
              state_q <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          rad_q <= {rad_q[61:0], 2'b00};
          if (!sq_try[65]) begin
            rem_q <= sq_try;
            root_q <= {root_q[30:0], 1'b1};
          end else begin
            rem_q <= {2'b0, sq_shift};
            root_q <= {root_q[30:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) state_q <= S_AVG;
        end
        S_AVG: begin
          avg_q <= first_q ? root_q : avg_sum[32:1];
          state_q <= S_SEG;
        end
        S_SEG: begin
          if (force_q || {2'b0, root_q} > thresh) begin
            n_q <= (total > 32'(SegLimit)) ? SegLimit : total[5:0];
          end else begin
            n_q <= 6'(BaseSegments);
          end
          j_q <= 6'd1;
          axis_q <= 1'b0;
          state_q <= first_q ? S_START : S_MUL;
          term_q <= 2'd0;
          num_q <= '0;
        end
        S_START: begin
          if (out_load) begin
            ox_q <= sx_q; oy_q <= sy_q; last_q <= 1'b0; ovalid_q <= 1'b1;
            state_q <= S_MUL;
          end
        end
        // accumulate the three weighted terms, then add half the divisor
        S_MUL: begin
          case (term_q)
            2'd2: begin
              num_q <= acc_sum;
              den_q <= 12'({6'd0, n_q} * {6'd0, n_q});
              term_q <= 2'd3;
            end
            2'd3: begin
              num_q <= num_q + 66'(den_q[11:1]);
              rem_q <= '0; cnt_q <= '0;
              term_q <= 2'd0;
              state_q <= S_DIV;
            end
            default: begin
              num_q <= acc_sum;
              term_q <= term_q + 2'd1;
            end
          endcase
        end
        S_DIV: begin
          if (!dv_try[65]) begin
            rem_q <= dv_try;
            quo_q <= {quo_q[29:0], 1'b1};
          end else begin
            rem_q <= dv_shift;
            quo_q <= {quo_q[29:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            num_q <= '0;
            if (!axis_q) begin
              rx_q <= {quo_q[30:0], !dv_try[65]} ^ 32'h8000_0000;
              axis_q <= 1'b1;
              state_q <= S_MUL;
            end else begin
              ry_q <= {quo_q[30:0], !dv_try[65]} ^ 32'h8000_0000;
              state_q <= S_EMIT;
            end
          end else begin
            num_q <= {num_q[64:0], 1'b0};
          end
        end
        S_EMIT: begin
          if (out_load) begin
            ox_q <= rx_q;
            oy_q <= ry_q;
            last_q <= (j_q == n_q);
            ovalid_q <= 1'b1;
            axis_q <= 1'b0;
            if (j_q == n_q) begin
              first_q <= 1'b0;
              sx_q <= ex_q; sy_q <= ey_q;
              phase_q <= 2'd1;
              state_q <= S_IDLE;
            end else begin
              j_q <= j_q + 6'd1;
              state_q <= S_MUL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
